>>> rtl/gmig_pkg.sv
// Package with the shared types, constants and helper functions of the mesh index generator.
`timescale 1ns / 1ps

package gmig_pkg;

    localparam int INDEX_BITS_DEF = 16;
    localparam int VERTEX_W       = 16;

    localparam logic [7:0] CELLS_RESET = 8'd101;
    localparam logic [7:0] CELLS_MIN   = 8'd1;
    localparam logic [7:0] CELLS_MAX   = 8'd252;

    typedef enum logic [1:0] {
        PH_GRID    = 2'd0,
        PH_BORDER  = 2'd1,
        PH_HORIZON = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        SIDE_FRONT = 2'd0,
        SIDE_RIGHT = 2'd1,
        SIDE_BACK  = 2'd2,
        SIDE_LEFT  = 2'd3
    } t_side;

    // Mesh geometry, recomputed only at reset and when the size register is written.
    typedef struct packed {
        logic [7:0]          n;         // cells per side
        logic [8:0]          s;         // vertices per side
        logic [VERTEX_W-1:0] sn;        // s * n
        logic [VERTEX_W-1:0] first;     // first border vertex, s * s
        logic [VERTEX_W-1:0] ring_end;  // one past the last border vertex
    } t_geom;

    // Walk state of the triangle sequence.
    typedef struct packed {
        t_phase              phase;
        t_side               side;
        logic [7:0]          row;
        logic [7:0]          col;
        logic                second_half;
        logic [VERTEX_W-1:0] cell_base;
        logic [VERTEX_W-1:0] ring_v;
        logic [VERTEX_W-1:0] edge_v;
    } t_seq;

    localparam t_seq SEQ_START = '{
        phase:       PH_GRID,
        side:        SIDE_FRONT,
        row:         8'd0,
        col:         8'd0,
        second_half: 1'b0,
        cell_base:   '0,
        ring_v:      '0,
        edge_v:      '0
    };

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
        logic [VERTEX_W-1:0] vertex_c;
        logic [1:0]          region;
        logic                last_triangle;
    } t_tri;

    function automatic logic [7:0] clamp_cells(input logic [7:0] value);
        logic [7:0] v;
        begin
            v = value;
            if (v < CELLS_MIN) begin
                v = CELLS_MIN;
            end
            if (v > CELLS_MAX) begin
                v = CELLS_MAX;
            end
            return v;
        end
    endfunction

    function automatic t_geom geom_of(input logic [7:0] n);
        t_geom      g;
        logic [8:0] s;
        begin
            s          = {1'b0, n} + 9'd1;
            g.n        = n;
            g.s        = s;
            g.sn       = VERTEX_W'(s) * VERTEX_W'(n);
            g.first    = VERTEX_W'(s) * VERTEX_W'(s);
            g.ring_end = g.first + VERTEX_W'({n, 2'b00});
            return g;
        end
    endfunction

    // Grid vertex at which a border side starts walking.
    function automatic logic [VERTEX_W-1:0] side_start(input t_side side, input t_geom g);
        logic [VERTEX_W-1:0] v;
        begin
            case (side)
                SIDE_FRONT: v = g.sn;
                SIDE_RIGHT: v = g.sn + VERTEX_W'(g.n);
                SIDE_BACK:  v = VERTEX_W'(g.n);
                SIDE_LEFT:  v = '0;
                default:    v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

>>> rtl/gmig_if.sv
// Valid/ready channel interfaces for the request and triangle streams.
`timescale 1ns / 1ps

interface gmig_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface gmig_tri_if;
    logic                          valid;
    logic                          ready;
    logic [gmig_pkg::VERTEX_W-1:0] vertex_a;
    logic [gmig_pkg::VERTEX_W-1:0] vertex_b;
    logic [gmig_pkg::VERTEX_W-1:0] vertex_c;
    logic [1:0]                    region;
    logic                          last_triangle;

    modport source (output valid, output vertex_a, output vertex_b, output vertex_c,
                    output region, output last_triangle, input ready);
    modport sink   (input valid, input vertex_a, input vertex_b, input vertex_c,
                    input region, input last_triangle, output ready);
endinterface

>>> rtl/grid_ring_mesh_index_generator.sv
// Top level of the square mesh triangle index generator.
// A result appears in the output register the cycle after its request transaction.
// Throughput: one triangle per cycle; a request is taken whenever the output register is
// empty or is being drained in the same cycle.
// Reset (synchronous, active low) sets cells_per_side to 101 and the walk to the first
// grid triangle, and empties the output register.
`timescale 1ns / 1ps

module grid_ring_mesh_index_generator #(
    parameter int INDEX_BITS = gmig_pkg::INDEX_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    gmig_req_if.sink    i_req,
    gmig_tri_if.source  o_tri
);

    // Walk state and the geometry derived from the size register. The geometry
    // (vertices per side, border base and so on) is computed once at write time so
    // that the per-triangle path holds only adds, compares and selects.
    gmig_pkg::t_seq  r_seq;
    gmig_pkg::t_seq  n_seq;
    gmig_pkg::t_geom r_geom;
    gmig_pkg::t_tri  n_tri;
    gmig_pkg::t_tri  r_tri;
    logic            r_out_valid;
    logic            req_ready;
    logic            req_take;

    // The output register accepts a new triangle when it is empty or drained this cycle.
    assign req_ready   = !r_out_valid || o_tri.ready;
    assign req_take    = i_req.valid && req_ready;
    assign i_req.ready = req_ready;

    gmig_step #(
        .INDEX_BITS (INDEX_BITS)
    ) u_step (
        .i_geom    (r_geom),
        .i_seq     (r_seq),
        .i_restart (i_req.restart),
        .o_seq     (n_seq),
        .o_tri     (n_tri)
    );

    // Control state. A size write also restarts the walk at the first grid triangle;
    // the user must write only while the block is idle; the block itself does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom      <= gmig_pkg::geom_of(gmig_pkg::CELLS_RESET);
            r_seq       <= gmig_pkg::SEQ_START;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_geom <= gmig_pkg::geom_of(gmig_pkg::clamp_cells(i_cfg_data));
                r_seq  <= gmig_pkg::SEQ_START;
            end else if (req_take) begin
                r_seq <= n_seq;
            end
            if (req_take) begin
                r_out_valid <= 1'b1;
            end else if (o_tri.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is qualified by the valid flag.
    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_tri <= n_tri;
        end
    end

    assign o_tri.valid         = r_out_valid;
    assign o_tri.vertex_a      = r_tri.vertex_a;
    assign o_tri.vertex_b      = r_tri.vertex_b;
    assign o_tri.vertex_c      = r_tri.vertex_c;
    assign o_tri.region        = r_tri.region;
    assign o_tri.last_triangle = r_tri.last_triangle;

endmodule

>>> rtl/gmig_step.sv
// Combinational step: one triangle from the walk state, plus the next walk state.
`timescale 1ns / 1ps

module gmig_step #(
    parameter int INDEX_BITS = gmig_pkg::INDEX_BITS_DEF
) (
    input  gmig_pkg::t_geom i_geom,
    input  gmig_pkg::t_seq  i_seq,
    input  logic            i_restart,
    output gmig_pkg::t_seq  o_seq,
    output gmig_pkg::t_tri  o_tri
);

    localparam int VW      = gmig_pkg::VERTEX_W;
    localparam int MASK_W  = (INDEX_BITS < VW) ? INDEX_BITS : VW;
    localparam logic [VW-1:0] IDX_MASK = VW'((65'd1 << MASK_W) - 65'd1);

    gmig_pkg::t_seq eff;
    logic [VW-1:0]  p00, p01, p10, p11, ring_inc;
    logic [8:0]     col_inc, row_inc;
    logic           wrap, last;
    logic [1:0]     region;

    always_comb begin
        if (i_restart || !(i_seq.phase inside {gmig_pkg::PH_GRID, gmig_pkg::PH_BORDER,
                                               gmig_pkg::PH_HORIZON})) begin
            eff = gmig_pkg::SEQ_START;
        end else begin
            eff = i_seq;
        end

        col_inc  = {1'b0, eff.col} + 9'd1;
        row_inc  = {1'b0, eff.row} + 9'd1;
        wrap     = col_inc >= {1'b0, i_geom.n};
        ring_inc = eff.ring_v + VW'(1);
        p00      = '0;
        p01      = '0;
        p10      = '0;
        p11      = '0;
        last     = 1'b0;
        region   = eff.phase;

        case (eff.phase)
            gmig_pkg::PH_GRID: begin
                p00 = eff.cell_base;
                p10 = eff.cell_base + VW'(1);
                p01 = eff.cell_base + VW'(i_geom.s);
                p11 = p01 + VW'(1);
            end
            gmig_pkg::PH_BORDER: begin
                p00 = eff.edge_v;
                case (eff.side)
                    gmig_pkg::SIDE_FRONT: p10 = eff.edge_v + VW'(1);
                    gmig_pkg::SIDE_RIGHT: p10 = eff.edge_v - VW'(i_geom.s);
                    gmig_pkg::SIDE_BACK:  p10 = eff.edge_v - VW'(1);
                    gmig_pkg::SIDE_LEFT:  p10 = eff.edge_v + VW'(i_geom.s);
                    default:              p10 = eff.edge_v;
                endcase
                p01 = eff.ring_v;
                // The last border vertex wraps back to the first.
                p11 = (ring_inc >= i_geom.ring_end) ? i_geom.first : ring_inc;
            end
            gmig_pkg::PH_HORIZON: begin
                p00  = eff.ring_v;
                p10  = ring_inc;
                p01  = eff.edge_v;
                p11  = eff.edge_v + VW'(1);
                last = wrap && eff.second_half;
            end
            default: begin
                region = 2'd0;
            end
        endcase

        o_tri.vertex_a      = p00 & IDX_MASK;
        o_tri.vertex_b      = (eff.second_half ? p11 : p01) & IDX_MASK;
        o_tri.vertex_c      = (eff.second_half ? p10 : p11) & IDX_MASK;
        o_tri.region        = region;
        o_tri.last_triangle = last;

        o_seq = eff;
        if (!eff.second_half) begin
            o_seq.second_half = 1'b1;
        end else begin
            o_seq.second_half = 1'b0;
            o_seq.col         = col_inc[7:0];
            case (eff.phase)
                gmig_pkg::PH_GRID: begin
                    o_seq.cell_base = eff.cell_base + VW'(1);
                    if (wrap) begin
                        o_seq.col       = 8'd0;
                        o_seq.cell_base = eff.cell_base + VW'(2);
                        o_seq.row       = row_inc[7:0];
                        if (row_inc >= {1'b0, i_geom.n}) begin
                            o_seq.row    = 8'd0;
                            o_seq.phase  = gmig_pkg::PH_BORDER;
                            o_seq.side   = gmig_pkg::SIDE_FRONT;
                            o_seq.edge_v = i_geom.sn;
                            o_seq.ring_v = i_geom.first;
                        end
                    end
                end
                gmig_pkg::PH_BORDER: begin
                    o_seq.ring_v = ring_inc;
                    if (wrap) begin
                        o_seq.col = 8'd0;
                        if (eff.side == gmig_pkg::SIDE_LEFT) begin
                            o_seq.side   = gmig_pkg::SIDE_FRONT;
                            o_seq.phase  = gmig_pkg::PH_HORIZON;
                            o_seq.ring_v = i_geom.first;
                            o_seq.edge_v = i_geom.ring_end;
                        end else begin
                            o_seq.side   = gmig_pkg::t_side'(eff.side + 2'd1);
                            o_seq.edge_v = gmig_pkg::side_start(
                                gmig_pkg::t_side'(eff.side + 2'd1), i_geom);
                        end
                    end else begin
                        // Next edge vertex is this quad's other corner on the same edge.
                        o_seq.edge_v = p10;
                    end
                end
                gmig_pkg::PH_HORIZON: begin
                    o_seq.ring_v = ring_inc;
                    o_seq.edge_v = eff.edge_v + VW'(1);
                    if (wrap) begin
                        o_seq = gmig_pkg::SEQ_START;
                    end
                end
                default: begin
                    o_seq = gmig_pkg::SEQ_START;
                end
            endcase
        end
    end

endmodule
